@@ hdl/sqmm_pkg.sv @@
// Shared constants and types of the square matrix multiplier.
`default_nettype none
package sqmm_pkg;

  localparam int MAX_DIM = 64;

  localparam int DATA_W = 16;
  localparam int PROD_W = 2 * DATA_W;
  localparam int IDX_W  = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int ADDR_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int ACC_W  = PROD_W + $clog2(MAX_DIM) + 1;
  localparam int OUT_W  = 38;
  localparam int POS_W  = 6;
  localparam int SIZE_W = 7;
  localparam int CMP_W  = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic en;
    logic last;
  } mac_ctl_t;

endpackage
`default_nettype wire

@@ hdl/sqmm_store.sv @@
// Element stores of both matrices: one write port, one registered read port each.
`default_nettype none
module sqmm_store (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [sqmm_pkg::ADDR_W-1:0] waddr,
  input  wire logic [sqmm_pkg::DATA_W-1:0] a_wdata,
  input  wire logic [sqmm_pkg::DATA_W-1:0] b_wdata,
  input  wire logic [sqmm_pkg::ADDR_W-1:0] a_raddr,
  input  wire logic [sqmm_pkg::ADDR_W-1:0] b_raddr,
  output logic      [sqmm_pkg::DATA_W-1:0] a_rdata,
  output logic      [sqmm_pkg::DATA_W-1:0] b_rdata
);
  import sqmm_pkg::*;

  logic [DATA_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic [DATA_W-1:0] b_mem [MAX_DIM*MAX_DIM];

  always_ff @(posedge clk) begin
    if (we) begin
      a_mem[waddr] <= a_wdata;
      b_mem[waddr] <= b_wdata;
    end
    a_rdata <= a_mem[a_raddr];
    b_rdata <= b_mem[b_raddr];
  end

endmodule
`default_nettype wire

@@ hdl/sqmm_mac.sv @@
// Multiply-accumulate datapath with saturation of the finished sum.
`default_nettype none
module sqmm_mac (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire sqmm_pkg::mac_ctl_t                 ctl,
  input  wire logic signed [sqmm_pkg::DATA_W-1:0] a_data,
  input  wire logic signed [sqmm_pkg::DATA_W-1:0] b_data,
  output logic                                    done,
  output logic signed      [sqmm_pkg::OUT_W-1:0]  product_value
);
  import sqmm_pkg::*;

  localparam int EXT_W = (ACC_W > OUT_W) ? ACC_W : OUT_W;
  localparam logic signed [EXT_W-1:0] SAT_MAX =
    {{(EXT_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [EXT_W-1:0] SAT_MIN =
    {{(EXT_W-OUT_W+1){1'b1}}, {(OUT_W-1){1'b0}}};

  logic signed [PROD_W-1:0] prod;
  mac_ctl_t                 p_ctl;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] contrib;
  logic signed [ACC_W-1:0]  sum;
  logic signed [EXT_W-1:0]  sum_ext;
  logic signed [OUT_W-1:0]  sat;

  assign contrib = p_ctl.en ? prod : '0;
  assign sum     = acc + ACC_W'(contrib);
  assign sum_ext = EXT_W'(sum);

  always_comb begin
    if (sum_ext > SAT_MAX) begin
      sat = SAT_MAX[OUT_W-1:0];
    end else if (sum_ext < SAT_MIN) begin
      sat = SAT_MIN[OUT_W-1:0];
    end else begin
      sat = sum_ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_data * b_data;
    if (p_ctl.last) begin
      product_value <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ctl <= '0;
      acc   <= '0;
      done  <= 1'b0;
    end else begin
      p_ctl <= ctl;
      done  <= p_ctl.last;
      if (p_ctl.last) begin
        acc <= '0;
      end else if (p_ctl.en) begin
        acc <= sum;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/square_matrix_multiply.sv @@
// Top level of the square matrix multiplier: command port, sequencer, stores.
// A load (cmd 0) writes one element of each matrix and gives no result; busy
// stays low. A read (cmd 1) walks row of A and column of B through the stores,
// one multiply-accumulate per cycle on the single read port of each store, and
// strobes done with product_value when the sum is finished; busy then drops in
// the cycle after done (when the size is zero or an index is out of range the
// result is 0). done is a one-cycle strobe: capture product_value in that
// cycle, it cannot be held off. Write matrix_size only while busy is low;
// values above 64 act as 64.
`default_nettype none
module square_matrix_multiply (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic                               cmd,
  input  wire logic        [sqmm_pkg::POS_W-1:0]  row,
  input  wire logic        [sqmm_pkg::POS_W-1:0]  col,
  input  wire logic signed [sqmm_pkg::DATA_W-1:0] a_value,
  input  wire logic signed [sqmm_pkg::DATA_W-1:0] b_value,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic        [sqmm_pkg::SIZE_W-1:0] cfg_data,
  output logic                                    done,
  output logic signed      [sqmm_pkg::OUT_W-1:0]  product_value
);
  import sqmm_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FLUSH, S_WAIT} state_t;

  state_t              state;
  logic [SIZE_W-1:0]   matrix_size;
  logic [DIM_W-1:0]    n;
  logic [IDX_W-1:0]    k;
  logic [ADDR_W-1:0]   a_addr;
  logic [ADDR_W-1:0]   b_addr;
  mac_ctl_t            ctl_issue;
  mac_ctl_t            ctl_data;

  logic                accept;
  logic                in_range;
  logic [DIM_W-1:0]    n_next;
  logic [ADDR_W-1:0]   waddr;
  logic                k_last;
  logic signed [DATA_W-1:0] a_rdata;
  logic signed [DATA_W-1:0] b_rdata;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign in_range  = (CMP_W'(row) < CMP_W'(MAX_DIM)) && (CMP_W'(col) < CMP_W'(MAX_DIM));
  assign n_next    = (CMP_W'(matrix_size) > CMP_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                             : DIM_W'(matrix_size);
  assign waddr     = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));
  assign k_last    = ((DIM_W'(k) + DIM_W'(1)) == n);

  always_comb begin
    ctl_issue = '0;
    unique case (state)
      S_RUN: begin
        ctl_issue.en   = 1'b1;
        ctl_issue.last = k_last;
      end
      S_FLUSH: begin
        ctl_issue.last = 1'b1;
      end
      default: ctl_issue = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      matrix_size <= SIZE_RESET;
      ctl_data    <= '0;
    end else begin
      ctl_data <= ctl_issue;
      if (cfg_valid && cfg_ready) begin
        matrix_size <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && cmd == CMD_READ) begin
            n      <= n_next;
            k      <= '0;
            a_addr <= waddr - ADDR_W'(col);
            b_addr <= ADDR_W'(col);
            if (!in_range || n_next == '0) begin
              state <= S_FLUSH;
            end else begin
              state <= S_RUN;
            end
          end
        end
        S_RUN: begin
          k      <= k + IDX_W'(1);
          a_addr <= a_addr + ADDR_W'(1);
          b_addr <= b_addr + ADDR_W'(MAX_DIM);
          if (k_last) begin
            state <= S_WAIT;
          end
        end
        S_FLUSH: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (done) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  sqmm_store u_store (
    .clk     (clk),
    .we      (accept && cmd == CMD_LOAD && in_range),
    .waddr   (waddr),
    .a_wdata (a_value),
    .b_wdata (b_value),
    .a_raddr (a_addr),
    .b_raddr (b_addr),
    .a_rdata (a_rdata),
    .b_rdata (b_rdata)
  );

  sqmm_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl_data),
    .a_data        (a_rdata),
    .b_data        (b_rdata),
    .done          (done),
    .product_value (product_value)
  );

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    done |-> (state == S_WAIT))
    else $error("result strobe outside of a read");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_READ) |=> busy)
    else $error("read beat did not start the sequencer");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_LOAD) |=> !busy)
    else $error("load beat left the block busy");

endmodule
`default_nettype wire
